@@ hdl/r2fft_pkg.sv @@
// shared constants, command/status types and twiddle table builder of the frame fft
package r2fft_pkg;

  localparam int unsigned POINTS       = 1024;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned TWIDDLE_BITS = 18;

  localparam int unsigned LOG_POINTS = $clog2(POINTS);
  localparam int unsigned BIN_BITS   = SAMPLE_BITS + LOG_POINTS;
  localparam int unsigned FRAC_BITS  = TWIDDLE_BITS - 1;
  localparam int unsigned HALF       = POINTS / 2;
  localparam int unsigned QUARTER    = POINTS / 4;
  localparam int unsigned ADDR_W     = LOG_POINTS;
  localparam int unsigned TI_W       = LOG_POINTS - 1;
  localparam int unsigned STAGE_W    = $clog2(LOG_POINTS);
  localparam int unsigned PROD_W     = BIN_BITS + TWIDDLE_BITS;
  localparam int unsigned SUM_W      = PROD_W + 1;

  localparam int unsigned IN_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = 2 * BIN_BITS + LOG_POINTS;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [63:0] PI4_Q30 = 64'd843314857;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic              ld_we;
    logic [ADDR_W-1:0] ld_addr;
    logic              emit_rd;
    logic [ADDR_W-1:0] emit_addr;
    logic              cp_rd;
    logic [ADDR_W-1:0] cp_addr;
    logic              bf_issue;
    logic [ADDR_W-1:0] bf_e;
    logic [ADDR_W-1:0] bf_o;
    logic [TI_W-1:0]   bf_ti;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  typedef logic [HALF-1:0][2*TWIDDLE_BITS-1:0] tw_rom_t;

  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    return sum;
  endfunction

  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd132; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd182; sum = sum - term;
    return sum;
  endfunction

  function automatic logic [TWIDDLE_BITS-1:0] round_twiddle(input logic [63:0] v,
                                                            input logic neg);
    logic [63:0] r;
    logic [63:0] top;
    r   = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    top = (64'd1 << FRAC_BITS) - 64'd1;
    if (r > top) begin
      r = top;
    end
    if (neg) begin
      r = 64'd0 - r;
    end
    return r[TWIDDLE_BITS-1:0];
  endfunction

  // entry j: {imag, real} of exp(-2*pi*i*j/POINTS)
  function automatic tw_rom_t build_rom();
    tw_rom_t     rom;
    logic [63:0] t;
    logic [63:0] oct;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] cm;
    logic [63:0] sm;
    logic [63:0] c;
    logic [63:0] s;
    for (int unsigned j = 0; j < HALF; j++) begin
      t   = 64'd8 * 64'(j);
      oct = t / POINTS;
      r   = t % POINTS;
      u   = oct[0] ? (64'(POINTS) - r) : r;
      x   = (PI4_Q30 * u) / POINTS;
      cm  = cos_q30(x);
      sm  = sin_q30(x);
      if (oct == 64'd0 || oct == 64'd3) begin
        c = cm;
        s = sm;
      end else begin
        c = sm;
        s = cm;
      end
      rom[j] = {round_twiddle(s, 1'b1), round_twiddle(c, oct >= 64'd2)};
    end
    return rom;
  endfunction

endpackage

@@ hdl/r2fft_ctrl.sv @@
// sequencer of the frame fft: load handshake, copy pass, butterfly stages
module r2fft_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  r2fft_pkg::stat_t  stat_i,
  output r2fft_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_COPY  = 4'b0010,
    ST_BFLY  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  localparam logic [r2fft_pkg::STAGE_W-1:0] LAST_STAGE =
    r2fft_pkg::STAGE_W'(r2fft_pkg::LOG_POINTS - 1);

  state_e                             state_q, state_d;
  logic [r2fft_pkg::ADDR_W-1:0]       load_cnt_q, load_cnt_d;
  logic                               done_q, done_d;
  logic [r2fft_pkg::ADDR_W:0]         cp_cnt_q, cp_cnt_d;
  logic [r2fft_pkg::TI_W-1:0]         bf_cnt_q, bf_cnt_d;
  logic [r2fft_pkg::STAGE_W-1:0]      stage_q, stage_d;
  logic                               phase_q, phase_d;
  logic [1:0]                         drain_q, drain_d;

  logic                               accept;
  logic [r2fft_pkg::TI_W-1:0]         kmask;
  logic [r2fft_pkg::ADDR_W-1:0]       e_addr;
  logic [r2fft_pkg::ADDR_W-1:0]       half_bit;

  assign s_ready_o = (state_q == ST_LOAD) && !stat_i.out_busy;
  assign accept    = s_valid_i && s_ready_o;

  // butterfly j of stage s: a zero bit goes in at position s
  assign kmask    = ~({r2fft_pkg::TI_W{1'b1}} << stage_q);
  assign half_bit = r2fft_pkg::ADDR_W'(1) << stage_q;
  assign e_addr   = ({1'b0, bf_cnt_q & ~kmask} << 1) | {1'b0, bf_cnt_q & kmask};

  always_comb begin
    cmd_o           = '0;
    cmd_o.ld_we     = accept;
    cmd_o.ld_addr   = load_cnt_q;
    cmd_o.emit_rd   = accept && done_q;
    cmd_o.emit_addr = load_cnt_q;
    cmd_o.cp_rd     = (state_q == ST_COPY) && !cp_cnt_q[r2fft_pkg::ADDR_W];
    cmd_o.cp_addr   = cp_cnt_q[r2fft_pkg::ADDR_W-1:0];
    cmd_o.bf_issue  = (state_q == ST_BFLY) && !phase_q;
    cmd_o.bf_e      = e_addr;
    cmd_o.bf_o      = e_addr | half_bit;
    cmd_o.bf_ti     = (bf_cnt_q & kmask) << (LAST_STAGE - stage_q);
  end

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    done_d     = done_q;
    cp_cnt_d   = cp_cnt_q;
    bf_cnt_d   = bf_cnt_q;
    stage_d    = stage_q;
    phase_d    = phase_q;
    drain_d    = drain_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          load_cnt_d = load_cnt_q + 1'b1;
          if (load_cnt_q == {r2fft_pkg::ADDR_W{1'b1}}) begin
            state_d  = ST_COPY;
            cp_cnt_d = '0;
          end
        end
      end
      ST_COPY: begin
        cp_cnt_d = cp_cnt_q + 1'b1;
        if (cp_cnt_q[r2fft_pkg::ADDR_W]) begin
          state_d  = ST_BFLY;
          stage_d  = '0;
          bf_cnt_d = '0;
          phase_d  = 1'b0;
        end
      end
      ST_BFLY: begin
        phase_d = !phase_q;
        if (!phase_q) begin
          bf_cnt_d = bf_cnt_q + 1'b1;
          if (bf_cnt_q == {r2fft_pkg::TI_W{1'b1}}) begin
            state_d = ST_DRAIN;
            drain_d = '0;
            phase_d = 1'b0;
          end
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 2'd3) begin
          if (stage_q == LAST_STAGE) begin
            state_d = ST_LOAD;
            done_d  = 1'b1;
          end else begin
            state_d  = ST_BFLY;
            stage_d  = stage_q + 1'b1;
            bf_cnt_d = '0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      done_q     <= 1'b0;
      cp_cnt_q   <= '0;
      bf_cnt_q   <= '0;
      stage_q    <= '0;
      phase_q    <= 1'b0;
      drain_q    <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      done_q     <= done_d;
      cp_cnt_q   <= cp_cnt_d;
      bf_cnt_q   <= bf_cnt_d;
      stage_q    <= stage_d;
      phase_q    <= phase_d;
      drain_q    <= drain_d;
    end
  end

endmodule

@@ hdl/r2fft_dp.sv @@
// datapath of the frame fft: frame memories, twiddle rom, butterfly pipeline, output register
module r2fft_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  r2fft_pkg::cmd_t              cmd_i,
  input  logic [r2fft_pkg::IN_W-1:0]   s_data_i,
  input  logic                         m_ready_i,
  output r2fft_pkg::stat_t             stat_o,
  output logic                         m_valid_o,
  output logic [r2fft_pkg::OUT_W-1:0]  m_data_o,
  output logic                         m_last_o
);

  localparam int unsigned S  = r2fft_pkg::SAMPLE_BITS;
  localparam int unsigned B  = r2fft_pkg::BIN_BITS;
  localparam int unsigned TW = r2fft_pkg::TWIDDLE_BITS;
  localparam int unsigned AW = r2fft_pkg::ADDR_W;
  localparam int unsigned LG = r2fft_pkg::LOG_POINTS;
  localparam r2fft_pkg::tw_rom_t TW_ROM = r2fft_pkg::build_rom();
  localparam logic [r2fft_pkg::SUM_W-1:0] RND =
    r2fft_pkg::SUM_W'(1) << (r2fft_pkg::FRAC_BITS - 1);

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) begin
      r[b] = v[AW-1-b];
    end
    return r;
  endfunction

  logic [2*S-1:0] ld_mem [r2fft_pkg::POINTS];
  logic [2*B-1:0] wk_mem [r2fft_pkg::POINTS];

  logic [2*S-1:0] ld_rd_q;
  logic           cp_v_q;
  logic [AW-1:0]  cp_addr_q;

  // work memory ports and twiddle read register
  logic           wk_we;
  logic [AW-1:0]  wk_waddr;
  logic [2*B-1:0] wk_wdata;
  logic [AW-1:0]  rd_a_addr;
  logic           rd_a_en;
  logic [2*B-1:0] rd_a_q;
  logic [2*B-1:0] rd_b_q;
  logic [2*TW-1:0] tw_q;

  // butterfly pipeline
  logic           v1_q, v2_q, v3_q, v4_q;
  logic           z1_q, q1_q, z2_q, q2_q;
  logic [AW-1:0]  e1_q, o1_q, e2_q, o2_q, e3_q, o3_q, o4_q;
  logic signed [r2fft_pkg::PROD_W-1:0] prr_q, pii_q, pri_q, pir_q;
  logic [2*B-1:0] ed2_q, od2_q, ed3_q;
  logic [B-1:0]   tr3_q, tm3_q;
  logic [2*B-1:0] d4_q;
  logic [r2fft_pkg::SUM_W-1:0] sum_re, sum_im;
  logic [B-1:0]   tr, tm;
  logic [B-1:0]   s_re, s_im;

  // output side
  logic           pend_q;
  logic [AW-1:0]  idx_q;
  logic           out_v_q;
  logic [2*B-1:0] out_q;
  logic [AW-1:0]  out_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_we) begin
      ld_mem[cmd_i.ld_addr] <= s_data_i[2*S-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cp_rd) begin
      ld_rd_q <= ld_mem[cmd_i.cp_addr];
    end
    cp_addr_q <= cmd_i.cp_addr;
  end

  assign s_re = B'(signed'(ld_rd_q[S-1:0]));
  assign s_im = B'(signed'(ld_rd_q[2*S-1:S]));

  always_comb begin
    wk_we    = 1'b0;
    wk_waddr = o4_q;
    wk_wdata = d4_q;
    if (cp_v_q) begin
      wk_we    = 1'b1;
      wk_waddr = bitrev(cp_addr_q);
      wk_wdata = {s_im, s_re};
    end else if (v3_q) begin
      wk_we    = 1'b1;
      wk_waddr = e3_q;
      wk_wdata = {ed3_q[2*B-1:B] + tm3_q, ed3_q[B-1:0] + tr3_q};
    end else if (v4_q) begin
      wk_we    = 1'b1;
    end
  end

  assign rd_a_addr = cmd_i.bf_issue ? cmd_i.bf_e : cmd_i.emit_addr;
  assign rd_a_en   = cmd_i.bf_issue || cmd_i.emit_rd;

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    if (rd_a_en) begin
      rd_a_q <= wk_mem[rd_a_addr];
    end
    if (cmd_i.bf_issue) begin
      rd_b_q <= wk_mem[cmd_i.bf_o];
      tw_q   <= TW_ROM[cmd_i.bf_ti];
    end
  end

  // twiddle select and rounding
  assign sum_re = r2fft_pkg::SUM_W'(prr_q) - r2fft_pkg::SUM_W'(pii_q) + RND;
  assign sum_im = r2fft_pkg::SUM_W'(pri_q) + r2fft_pkg::SUM_W'(pir_q) + RND;

  always_comb begin
    if (z2_q) begin
      tr = od2_q[B-1:0];
      tm = od2_q[2*B-1:B];
    end else if (q2_q) begin
      tr = od2_q[2*B-1:B];
      tm = B'(0) - od2_q[B-1:0];
    end else begin
      tr = sum_re[r2fft_pkg::FRAC_BITS+B-1:r2fft_pkg::FRAC_BITS];
      tm = sum_im[r2fft_pkg::FRAC_BITS+B-1:r2fft_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q  <= (cmd_i.bf_ti == '0);
    q1_q  <= (cmd_i.bf_ti == r2fft_pkg::TI_W'(r2fft_pkg::QUARTER));
    e1_q  <= cmd_i.bf_e;
    o1_q  <= cmd_i.bf_o;
    prr_q <= signed'(rd_b_q[B-1:0])   * signed'(tw_q[TW-1:0]);
    pii_q <= signed'(rd_b_q[2*B-1:B]) * signed'(tw_q[2*TW-1:TW]);
    pri_q <= signed'(rd_b_q[B-1:0])   * signed'(tw_q[2*TW-1:TW]);
    pir_q <= signed'(rd_b_q[2*B-1:B]) * signed'(tw_q[TW-1:0]);
    ed2_q <= rd_a_q;
    od2_q <= rd_b_q;
    z2_q  <= z1_q;
    q2_q  <= q1_q;
    e2_q  <= e1_q;
    o2_q  <= o1_q;
    tr3_q <= tr;
    tm3_q <= tm;
    ed3_q <= ed2_q;
    e3_q  <= e2_q;
    o3_q  <= o2_q;
    d4_q  <= {ed3_q[2*B-1:B] - tm3_q, ed3_q[B-1:0] - tr3_q};
    o4_q  <= o3_q;
    idx_q <= cmd_i.emit_addr;
    if (pend_q) begin
      out_q     <= rd_a_q;
      out_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_v_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cp_v_q <= cmd_i.cp_rd;
      v1_q   <= cmd_i.bf_issue;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      pend_q <= cmd_i.emit_rd;
      if (pend_q) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy = pend_q || (out_v_q && !m_ready_i);
  assign m_valid_o       = out_v_q;
  assign m_data_o        = r2fft_pkg::OUT_W'({out_idx_q, out_q});
  assign m_last_o        = (out_idx_q == {LG{1'b1}});

endmodule

@@ hdl/radix2_fft_frame.sv @@
// top level of the framed radix-2 decimation-in-time fft
// Each beat on the slave side is one complex sample; POINTS samples make a frame. Once a
// frame is full the block stops taking beats and transforms it in place with one shared
// butterfly: a copy pass into bit-reversed order, then log2(POINTS) stages of POINTS/2
// butterflies, issued only while phase_q is low so that the single write port of the
// work memory can store both results of each, plus a pipeline drain per stage. While
// the next frame loads, every accepted sample returns one bin of the previous frame in
// natural order, tlast on the final bin; in that phase no new beat is taken while the
// bin read for the last one is still on its way from the work memory into the output
// register. Before the first frame has been transformed samples produce no output
// beats. Bins carry full bit growth (sample width plus log2(POINTS)) and wrap rather
// than saturate.
module radix2_fft_frame (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample_re [15:0], sample_im [31:16]
  input  logic [r2fft_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // bin_re [25:0], bin_im [51:26], bin_index [61:52], zero pad above
  output logic [r2fft_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // last_bin
  output logic                         m_axis_tlast
);

  r2fft_pkg::cmd_t  cmd;
  r2fft_pkg::stat_t stat;

  // sequencer: counters and stage control
  r2fft_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // memories, butterfly and output beat register
  r2fft_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .s_data_i  (s_axis_tdata),
    .m_ready_i (m_axis_tready),
    .stat_o    (stat),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

@@ dv/radix2_fft_frame_test.sv @@
// self-checking testbench of the framed radix-2 fft: random samples in, predicted bins checked
`timescale 1ns / 100ps

module radix2_fft_frame_test;
  import r2fft_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] im;
    logic signed [SAMPLE_BITS-1:0] re;
  } sample_t;

  typedef struct packed {
    logic [BIN_BITS-1:0] re;
    logic [BIN_BITS-1:0] im;
    logic [ADDR_W-1:0]   idx;
    logic                last;
  } bin_t;

  logic               clk_i;
  logic               rst_ni;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic               m_axis_tlast;

  radix2_fft_frame dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor state
  sample_t                   frame_in [POINTS];
  logic signed [63:0]        spec_re [POINTS];
  logic signed [63:0]        spec_im [POINTS];
  logic [2*TWIDDLE_BITS-1:0] cos_sin [HALF];
  int unsigned               fill_pos;
  int unsigned               read_pos;
  bit                        have_spectrum;

  sample_t     pending_samples[$];
  bin_t        expected_bins[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_send;
  bit          in_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] wrap_bin(input logic signed [63:0] v);
    logic [BIN_BITS-1:0] t;
    t = v[BIN_BITS-1:0];
    return 64'(signed'(t));
  endfunction

  function automatic int unsigned reverse_bits(input int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 0; b < LOG_POINTS; b++) r = (r << 1) | ((v >> b) & 1);
    return r;
  endfunction

  // rom contents, built independently from the shared Taylor series definition
  task automatic fill_cos_sin();
    longint unsigned t, oct, r, u, x, x2, cterm, csum, sterm, ssum, c, s, rc, rs, top;
    for (int j = 0; j < HALF; j++) begin
      t = 8 * j; oct = t / POINTS; r = t % POINTS;
      u = oct[0] ? POINTS - r : r;
      x = (843314857 * u) / POINTS;
      x2 = (x * x) >> 30;
      sterm = x; ssum = x; cterm = 1 << 30; csum = 1 << 30;
      for (int n = 1; n <= 7; n++) begin
        sterm = ((sterm * x2) >> 30) / ((2 * n) * (2 * n + 1));
        cterm = ((cterm * x2) >> 30) / ((2 * n - 1) * (2 * n));
        if (n % 2) begin
          ssum -= sterm; csum -= cterm;
        end else begin
          ssum += sterm; csum += cterm;
        end
      end
      if (oct == 0 || oct == 3) begin
        c = csum; s = ssum;
      end else begin
        c = ssum; s = csum;
      end
      top = (1 << FRAC_BITS) - 1;
      rc = (c + (1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      rs = (s + (1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (rc > top) rc = top;
      if (rs > top) rs = top;
      if (oct >= 2) rc = -rc;
      rs = -rs;
      cos_sin[j] = {rs[TWIDDLE_BITS-1:0], rc[TWIDDLE_BITS-1:0]};
    end
  endtask

  task automatic transform_frame();
    int unsigned half_len, stride, ti;
    logic signed [63:0] wr, wi, tr, tm, er, ei, orr, oi;
    logic signed [63:0] rnd;
    rnd = 64'sd1 <<< (FRAC_BITS - 1);
    for (int i = 0; i < POINTS; i++) begin
      spec_re[reverse_bits(i)] = 64'(frame_in[i].re);
      spec_im[reverse_bits(i)] = 64'(frame_in[i].im);
    end
    for (int len = 2; len <= POINTS; len *= 2) begin
      half_len = len / 2; stride = POINTS / len;
      for (int base = 0; base < POINTS; base += len) begin
        for (int k = 0; k < half_len; k++) begin
          er = spec_re[base+k]; ei = spec_im[base+k];
          orr = spec_re[base+k+half_len]; oi = spec_im[base+k+half_len];
          ti = (k * stride) % HALF;
          if (ti == 0) begin
            tr = orr; tm = oi;
          end else if (ti == QUARTER) begin
            tr = oi; tm = -orr;
          end else begin
            wr = 64'(signed'(cos_sin[ti][TWIDDLE_BITS-1:0]));
            wi = 64'(signed'(cos_sin[ti][2*TWIDDLE_BITS-1:TWIDDLE_BITS]));
            tr = (orr * wr - oi * wi + rnd) >>> FRAC_BITS;
            tm = (orr * wi + oi * wr + rnd) >>> FRAC_BITS;
          end
          spec_re[base+k+half_len] = wrap_bin(er - tr);
          spec_im[base+k+half_len] = wrap_bin(ei - tm);
          spec_re[base+k] = wrap_bin(er + tr);
          spec_im[base+k] = wrap_bin(ei + tm);
        end
      end
    end
  endtask

  // one accepted sample: emit previous bin, store, transform on a full frame
  task automatic predict_sample(input sample_t smp);
    bin_t b;
    if (have_spectrum) begin
      b.re = spec_re[read_pos][BIN_BITS-1:0];
      b.im = spec_im[read_pos][BIN_BITS-1:0];
      b.idx = read_pos[ADDR_W-1:0];
      b.last = (read_pos == POINTS - 1);
      expected_bins.push_back(b);
      read_pos = (read_pos + 1) % POINTS;
    end
    frame_in[fill_pos] = smp;
    fill_pos++;
    if (fill_pos == POINTS) begin
      fill_pos = 0;
      transform_frame();
      have_spectrum = 1'b1;
      read_pos = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // sender and receiver: a beat stays on the bus until taken, tready is set at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_samples.size() != 0 && !hold_send
            && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_W'(pending_samples[0]);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // prediction on accepted samples and checking of output beats
  always @(posedge clk_i) begin
    bin_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_taken) begin
      predict_sample(sample_t'(s_axis_tdata[2*SAMPLE_BITS-1:0]));
      void'(pending_samples.pop_front());
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.re = m_axis_tdata[BIN_BITS-1:0];
      got.im = m_axis_tdata[2*BIN_BITS-1:BIN_BITS];
      got.idx = m_axis_tdata[2*BIN_BITS+ADDR_W-1:2*BIN_BITS];
      got.last = m_axis_tlast;
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected beat", got.idx, 0);
      end else begin
        want = expected_bins.pop_front();
        if (got.re !== want.re) report_mismatch("bin_re", got.re, want.re);
        if (got.im !== want.im) report_mismatch("bin_im", got.im, want.im);
        if (got.idx !== want.idx) report_mismatch("bin_index", got.idx, want.idx);
        if (got.last !== want.last) report_mismatch("last_bin", got.last, want.last);
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_part(input int unsigned kind);
    case (kind)
      0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: return SAMPLE_BITS'($urandom_range(255)) - 128;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_frame(input int unsigned mode);
    sample_t smp;
    for (int i = 0; i < POINTS; i++) begin
      case (mode)
        0: begin  // impulse then zeros
          smp.re = (i == 0) ? 16'sh7fff : 0; smp.im = (i == 0) ? 16'sh8000 : 0;
        end
        1: begin  // full scale in both parts, worst case growth
          smp.re = 16'sh7fff; smp.im = 16'sh7fff;
        end
        2: begin
          smp.re = 16'sh8000; smp.im = 16'sh8000;
        end
        3: begin  // alternating extremes
          smp.re = i[0] ? 16'sh8000 : 16'sh7fff; smp.im = i[1] ? 16'sh7fff : 16'sh8000;
        end
        default: begin
          smp.re = rand_part($urandom_range(9)); smp.im = rand_part($urandom_range(9));
        end
      endcase
      pending_samples.push_back(smp);
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_bins.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    cycles = 0;
    fill_pos = 0;
    read_pos = 0;
    have_spectrum = 1'b0;
    hold_send = 1'b0;
    in_taken = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 82;
    fill_cos_sin();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames: impulse, both full-scale corners, alternating extremes
    for (int m = 0; m < 4; m++) queue_frame(m);
    wait (pending_samples.size() < POINTS);
    send_idle_pct = 82;
    recv_idle_pct = 8;
    queue_frame(4);
    wait (pending_samples.size() == 0);
    // pause the sender until every bin owed so far has come out
    hold_send = 1'b1;
    wait (expected_bins.size() == 0);
    hold_send = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_frame(4);
    // one more frame flushes the bins of the last random frame
    queue_frame(4);
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
